// ----- rtl/aic_pkg.sv -----
// ----------------------------------------------------------------------------
// Alarm indicator controller package
// Shared types, command and message codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package aic_pkg;

  localparam int TIME_W = 32;
  localparam int IVAL_W = 16;
  localparam int WD_W   = 20;
  localparam int CODE_W = 8;
  localparam int IDX_W  = 2;

  localparam logic [WD_W-1:0]   WD_MAX         = {WD_W{1'b1}};
  localparam logic [IVAL_W-1:0] POLL_RESET     = 16'd100;
  localparam logic [IVAL_W-1:0] TOGGLE_RESET   = 16'd500;
  localparam logic [WD_W-1:0]   WD_LIMIT_RESET = 20'd15000;

  localparam logic [IDX_W-1:0] CFG_POLL   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_TOGGLE = 2'd1;
  localparam logic [IDX_W-1:0] CFG_WD     = 2'd2;

  localparam logic [CODE_W-1:0] CMD_GREEN  = 8'h47;
  localparam logic [CODE_W-1:0] CMD_YELLOW = 8'h59;
  localparam logic [CODE_W-1:0] CMD_RED    = 8'h52;
  localparam logic [CODE_W-1:0] CMD_FIRE   = 8'h46;
  localparam logic [CODE_W-1:0] CMD_STOP   = 8'h53;
  localparam logic [CODE_W-1:0] CMD_BUZZ   = 8'h42;
  localparam logic [CODE_W-1:0] CMD_QUIET  = 8'h62;
  localparam logic [CODE_W-1:0] CMD_HEART  = 8'h48;

  localparam logic [CODE_W-1:0] MSG_HEART  = 8'h68;
  localparam logic [CODE_W-1:0] MSG_FLAME  = 8'h46;
  localparam logic [CODE_W-1:0] MSG_CLEAR  = 8'h66;
  localparam logic [CODE_W-1:0] MSG_NONE   = 8'h00;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_INTER = 2'd1,
    MODE_CONST = 2'd2
  } mode_t;

  typedef struct packed {
    logic              last;
    logic [CODE_W-1:0] msg_code;
    logic              msg_valid;
    logic              buzzer_drive;
    logic              lamp_green;
    logic              lamp_yellow;
    logic              lamp_red;
  } res_t;

  typedef struct packed {
    logic valid;
    logic dual;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

`default_nettype wire

// ----- rtl/alarm_indicator_controller.sv -----
// ----------------------------------------------------------------------------
// Alarm indicator controller
// Lamp, buzzer and watchdog control from sensor ticks and host commands.
// ----------------------------------------------------------------------------
// Results are registered in the result queue before they reach the output.
// Throughput: one input transaction per cycle while the three-entry result queue
// holds at most one entry; a heartbeat with a latched flame yields two results.
// Reset: synchronous, active low; registers return to 100, 500 and 15000, all
// lamps, the buzzer pin, counters and the queue are cleared.
`default_nettype none

module alarm_indicator_controller import aic_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // [0] flame_seen, [8:1] cmd_byte, [15:9] zero
  input  wire logic [15:0]       in_tdata,
  // [0] req_type
  input  wire logic              in_tuser,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // [0] lamp_red, [1] lamp_yellow, [2] lamp_green, [3] buzzer_drive,
  // [4] msg_valid, [12:5] msg_code, [15:13] zero
  output logic [15:0]            out_tdata,
  output logic                   out_tlast,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [WD_W-1:0]   cfg_data
);

  push_t push;
  res_t  head;
  logic  room;

  assign cfg_ready = 1'b1;
  assign in_tready = room;

  aic_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_we (cfg_valid && cfg_ready),
    .cfg_idx(cfg_index),
    .cfg_val(cfg_data),
    .acc    (in_tvalid && in_tready),
    .is_cmd (in_tuser),
    .flame  (in_tdata[0]),
    .cmd    (in_tdata[8:1]),
    .push   (push)
  );

  aic_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .q_valid(out_tvalid),
    .q_data (head),
    .q_pop  (out_tready)
  );

  assign out_tdata = {3'b000, head.msg_code, head.msg_valid, head.buzzer_drive,
                      head.lamp_green, head.lamp_yellow, head.lamp_red};
  assign out_tlast = head.last;

endmodule

`default_nettype wire

// ----- rtl/aic_core.sv -----
// ----------------------------------------------------------------------------
// Alarm indicator controller core
// Holds the configuration and controller state and works out one transaction
// in a single pass, handing up to two results to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module aic_core import aic_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_idx,
  input  wire logic [WD_W-1:0]   cfg_val,
  input  wire logic              acc,
  input  wire logic              is_cmd,
  input  wire logic              flame,
  input  wire logic [CODE_W-1:0] cmd,
  output push_t                  push
);

  logic [IVAL_W-1:0] poll_iv_r, toggle_iv_r;
  logic [WD_W-1:0]   wd_limit_r;

  logic [TIME_W-1:0] now_r, now_nxt;
  logic [TIME_W-1:0] ltog_r, ltog_nxt;
  logic [TIME_W-1:0] lpoll_r, lpoll_nxt;
  mode_t             mode_r, mode_nxt;
  logic              rem_r, rem_nxt;
  logic              fl_r, fl_nxt;
  logic [WD_W-1:0]   wd_r, wd_nxt;
  logic [3:0]        lamps_r, lamps_nxt;

  always_comb begin
    logic              mvalid;
    logic [CODE_W-1:0] mcode;
    logic              two;
    logic [TIME_W-1:0] nt;
    logic [WD_W-1:0]   w;
    nt        = now_r + TIME_W'(1);
    now_nxt   = now_r;
    ltog_nxt  = ltog_r;
    lpoll_nxt = lpoll_r;
    mode_nxt  = mode_r;
    rem_nxt   = rem_r;
    fl_nxt    = fl_r;
    wd_nxt    = wd_r;
    lamps_nxt = lamps_r;
    mvalid    = 1'b0;
    mcode     = MSG_NONE;
    two       = 1'b0;
    w         = wd_r;
    if (is_cmd) begin
      wd_nxt = '0;
      unique case (cmd)
        CMD_GREEN: begin
          lamps_nxt = {lamps_r[3], 3'b100};
          mode_nxt  = MODE_OFF;
        end
        CMD_YELLOW: begin
          lamps_nxt = {lamps_r[3], 3'b010};
          mode_nxt  = MODE_OFF;
        end
        CMD_RED: begin
          lamps_nxt = {lamps_r[3], 3'b001};
          mode_nxt  = MODE_INTER;
        end
        CMD_FIRE: begin
          lamps_nxt = {lamps_r[3], 3'b001};
          mode_nxt  = MODE_CONST;
        end
        CMD_STOP: begin
          lamps_nxt = '0;
          mode_nxt  = MODE_OFF;
        end
        CMD_BUZZ: mode_nxt = MODE_CONST;
        CMD_QUIET: begin
          mode_nxt     = MODE_OFF;
          lamps_nxt[3] = 1'b0;
        end
        CMD_HEART: begin
          mvalid = 1'b1;
          mcode  = MSG_HEART;
          two    = fl_r;
        end
        default: ;
      endcase
    end else begin
      now_nxt = nt;
      if ((nt - lpoll_r) >= TIME_W'(poll_iv_r)) begin
        if (flame != fl_r) begin
          mvalid = 1'b1;
          if (flame) begin
            mcode        = MSG_FLAME;
            lamps_nxt[0] = 1'b1;
            mode_nxt     = MODE_CONST;
          end else begin
            mcode        = MSG_CLEAR;
            lamps_nxt[0] = 1'b0;
            lamps_nxt[3] = 1'b0;
            lamps_nxt[2] = 1'b1;
            mode_nxt     = MODE_OFF;
          end
          fl_nxt = flame;
        end
        lpoll_nxt = nt;
      end
      unique case (mode_nxt)
        MODE_INTER: begin
          if ((nt - ltog_r) >= TIME_W'(toggle_iv_r)) begin
            rem_nxt      = !rem_r;
            lamps_nxt[3] = !rem_r;
            ltog_nxt     = nt;
          end
        end
        MODE_CONST: begin
          if (!rem_r) begin
            lamps_nxt[3] = 1'b1;
            rem_nxt      = 1'b1;
          end
        end
        default: begin
          if (rem_r) begin
            lamps_nxt[3] = 1'b0;
            rem_nxt      = 1'b0;
          end
        end
      endcase
      if (wd_r != WD_MAX) begin
        w = wd_r + WD_W'(1);
      end
      if (w > wd_limit_r) begin
        lamps_nxt = '0;
        mode_nxt  = MODE_OFF;
        w         = '0;
      end
      wd_nxt = w;
    end

    push.valid           = acc;
    push.dual            = two;
    push.r0.lamp_red     = lamps_nxt[0];
    push.r0.lamp_yellow  = lamps_nxt[1];
    push.r0.lamp_green   = lamps_nxt[2];
    push.r0.buzzer_drive = lamps_nxt[3];
    push.r0.msg_valid    = mvalid;
    push.r0.msg_code     = mcode;
    push.r0.last         = !two;
    push.r1              = push.r0;
    push.r1.msg_code     = MSG_FLAME;
    push.r1.last         = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_iv_r   <= POLL_RESET;
      toggle_iv_r <= TOGGLE_RESET;
      wd_limit_r  <= WD_LIMIT_RESET;
      now_r       <= '0;
      ltog_r      <= '0;
      lpoll_r     <= '0;
      mode_r      <= MODE_OFF;
      rem_r       <= 1'b0;
      fl_r        <= 1'b0;
      wd_r        <= '0;
      lamps_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_POLL:   poll_iv_r   <= cfg_val[IVAL_W-1:0];
          CFG_TOGGLE: toggle_iv_r <= cfg_val[IVAL_W-1:0];
          CFG_WD:     wd_limit_r  <= cfg_val;
          default: ;
        endcase
      end
      if (acc) begin
        now_r   <= now_nxt;
        ltog_r  <= ltog_nxt;
        lpoll_r <= lpoll_nxt;
        mode_r  <= mode_nxt;
        rem_r   <= rem_nxt;
        fl_r    <= fl_nxt;
        wd_r    <= wd_nxt;
        lamps_r <= lamps_nxt;
      end
    end
  end

  a_cmd_clears_wd: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_cmd |=> wd_r == '0)
    else $error("watchdog not cleared by a command");

  a_dual_only_heart: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid && push.dual |-> is_cmd && cmd == CMD_HEART && fl_r)
    else $error("second result without a heartbeat and latched flame");

  a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !is_cmd |=> now_r == $past(now_r) + TIME_W'(1))
    else $error("tick count did not advance");

endmodule

`default_nettype wire

// ----- rtl/aic_outq.sv -----
// ----------------------------------------------------------------------------
// Alarm indicator controller result queue
// Three-entry shift queue that registers results and decouples the result
// channel from the input channel.
// ----------------------------------------------------------------------------
`default_nettype none

module aic_outq import aic_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  push_t     push,
  output logic      room,
  output logic      q_valid,
  output res_t      q_data,
  input  wire logic q_pop
);

  localparam int DEPTH = 3;

  res_t       ent_r [DEPTH];
  res_t       ent_nxt [DEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign q_valid = cnt_r != 2'd0;
  assign q_data  = ent_r[0];
  assign room    = cnt_r <= 2'd1;
  assign pop     = q_valid && q_pop;

  always_comb begin
    logic [1:0] base;
    base = cnt_r - 2'(pop);
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && i < DEPTH - 1) begin
        ent_nxt[i] = ent_r[i+1];
      end else begin
        ent_nxt[i] = ent_r[i];
      end
      if (push.valid && base == 2'(i)) begin
        ent_nxt[i] = push.r0;
      end
      if (push.valid && push.dual && base + 2'd1 == 2'(i)) begin
        ent_nxt[i] = push.r1;
      end
    end
    cnt_nxt = base + (push.valid ? (push.dual ? 2'd2 : 2'd1) : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> room)
    else $error("result pushed into a full queue");

  a_dual_fill: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid && push.dual |=> cnt_r >= 2'd2)
    else $error("heartbeat pair not held in the queue");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !push.valid && !pop |=> $stable(cnt_r))
    else $error("queue fill changed without a transaction");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid && push.dual |-> !push.r0.last && push.r1.last)
    else $error("heartbeat pair marked wrongly");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Alarm indicator controller testbench
// Sends sensor ticks and host command bytes under several register settings,
// with random gaps on the input and random stalls on the result stream. Every
// result is checked field by field against a cycle-free model of the lamps,
// buzzer, flame poll and watchdog that this file keeps alongside the block.
// ----------------------------------------------------------------------------

module testbench;
  import aic_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic              is_reg;
    logic [IDX_W-1:0]  reg_idx;
    logic [WD_W-1:0]   reg_val;
    logic              is_cmd;
    logic              flame;
    logic [CODE_W-1:0] cmd;
    logic              typed;
    res_t              want;
  } row_t;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata   = '0;
  logic              in_tuser   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;
  logic              out_tlast;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index  = '0;
  logic [WD_W-1:0]   cfg_data   = '0;

  bit          in_fire, out_fire, cfg_fire;
  logic [15:0] out_word;
  logic        out_end;

  int   errors       = 0;
  int   idle_pct     = 25;
  int   stall_left   = 0;
  int   quiet_cycles = 0;
  logic flame_level  = 1'b0;

  res_t pending_results[$];
  res_t step_results[$];
  row_t stim_table [29];

  // Model state, reset values as the block comes out of reset
  logic [IVAL_W-1:0] poll_ival   = POLL_RESET;
  logic [IVAL_W-1:0] toggle_ival = TOGGLE_RESET;
  logic [WD_W-1:0]   wd_limit    = WD_LIMIT_RESET;
  logic [TIME_W-1:0] tick_now    = '0;
  logic [TIME_W-1:0] toggle_mark = '0;
  logic [TIME_W-1:0] poll_mark   = '0;
  logic [WD_W-1:0]   wd_count    = '0;
  mode_t             buzz_mode   = MODE_OFF;
  logic              buzz_mem    = 1'b0;
  logic              flame_held  = 1'b0;
  logic              red_on      = 1'b0;
  logic              yellow_on   = 1'b0;
  logic              green_on    = 1'b0;
  logic              pin_on      = 1'b0;

  alarm_indicator_controller uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Handshakes are judged at the falling edge before the rising edge that completes them.
  always @(negedge clk) begin
    in_fire  = rst_n && in_tvalid && (in_tready === 1'b1);
    out_fire = rst_n && (out_tvalid === 1'b1) && out_tready;
    cfg_fire = rst_n && cfg_valid && (cfg_ready === 1'b1);
    out_word = out_tdata;
    out_end  = out_tlast;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < idle_pct / 2) begin
      stall_left = $urandom_range(1, 15);
    end
    out_tready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    if (in_fire || out_fire || cfg_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (out_fire) begin
      got = {out_end, out_word[12:0]};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result expected none, got tdata %h tlast %b",
                 $time, out_word, out_end);
      end else begin
        want = pending_results.pop_front();
        check_field("lamp_red", 8'(want.lamp_red), 8'(got.lamp_red));
        check_field("lamp_yellow", 8'(want.lamp_yellow), 8'(got.lamp_yellow));
        check_field("lamp_green", 8'(want.lamp_green), 8'(got.lamp_green));
        check_field("buzzer_drive", 8'(want.buzzer_drive), 8'(got.buzzer_drive));
        check_field("msg_valid", 8'(want.msg_valid), 8'(got.msg_valid));
        check_field("msg_code", want.msg_code, got.msg_code);
        check_field("last", 8'(want.last), 8'(got.last));
      end
    end
  end

  function automatic res_t lamp_res(input logic r, input logic y, input logic g,
                                    input logic p, input logic mv,
                                    input logic [CODE_W-1:0] code, input logic fin);
    res_t x;
    x.lamp_red     = r;
    x.lamp_yellow  = y;
    x.lamp_green   = g;
    x.buzzer_drive = p;
    x.msg_valid    = mv;
    x.msg_code     = code;
    x.last         = fin;
    return x;
  endfunction

  function automatic res_t lamp_now(input logic mv, input logic [CODE_W-1:0] code,
                                    input logic fin);
    return lamp_res(red_on, yellow_on, green_on, pin_on, mv, code, fin);
  endfunction

  task automatic alarm_step(input logic is_cmd, input logic flame,
                            input logic [CODE_W-1:0] cmd);
    logic              mv;
    logic [CODE_W-1:0] mc;
    mv = 1'b0;
    mc = MSG_NONE;
    step_results.delete();
    if (is_cmd) begin
      wd_count = '0;
      case (cmd)
        CMD_GREEN: begin
          {red_on, yellow_on, green_on} = 3'b001;
          buzz_mode = MODE_OFF;
        end
        CMD_YELLOW: begin
          {red_on, yellow_on, green_on} = 3'b010;
          buzz_mode = MODE_OFF;
        end
        CMD_RED: begin
          {red_on, yellow_on, green_on} = 3'b100;
          buzz_mode = MODE_INTER;
        end
        CMD_FIRE: begin
          {red_on, yellow_on, green_on} = 3'b100;
          buzz_mode = MODE_CONST;
        end
        CMD_STOP: begin
          {red_on, yellow_on, green_on, pin_on} = 4'b0000;
          buzz_mode = MODE_OFF;
        end
        CMD_BUZZ: buzz_mode = MODE_CONST;
        CMD_QUIET: begin
          buzz_mode = MODE_OFF;
          pin_on = 1'b0;
        end
        CMD_HEART: begin
          mv = 1'b1;
          mc = MSG_HEART;
        end
        default: ;
      endcase
      if (cmd == CMD_HEART && flame_held) begin
        step_results.push_back(lamp_now(1'b1, MSG_HEART, 1'b0));
        step_results.push_back(lamp_now(1'b1, MSG_FLAME, 1'b1));
      end else begin
        step_results.push_back(lamp_now(mv, mc, 1'b1));
      end
    end else begin
      tick_now = tick_now + TIME_W'(1);
      if (tick_now - poll_mark >= TIME_W'(poll_ival)) begin
        if (flame != flame_held) begin
          mv = 1'b1;
          if (flame) begin
            mc = MSG_FLAME;
            red_on = 1'b1;
            buzz_mode = MODE_CONST;
          end else begin
            mc = MSG_CLEAR;
            red_on = 1'b0;
            buzz_mode = MODE_OFF;
            pin_on = 1'b0;
            green_on = 1'b1;
          end
          flame_held = flame;
        end
        poll_mark = tick_now;
      end
      case (buzz_mode)
        MODE_INTER: begin
          if (tick_now - toggle_mark >= TIME_W'(toggle_ival)) begin
            buzz_mem = ~buzz_mem;
            pin_on = buzz_mem;
            toggle_mark = tick_now;
          end
        end
        MODE_CONST: begin
          if (!buzz_mem) begin
            pin_on = 1'b1;
            buzz_mem = 1'b1;
          end
        end
        default: begin
          if (buzz_mem) begin
            pin_on = 1'b0;
            buzz_mem = 1'b0;
          end
        end
      endcase
      if (wd_count != WD_MAX) wd_count = wd_count + WD_W'(1);
      if (wd_count > wd_limit) begin
        {red_on, yellow_on, green_on, pin_on} = 4'b0000;
        buzz_mode = MODE_OFF;
        wd_count = '0;
      end
      step_results.push_back(lamp_now(mv, mc, 1'b1));
    end
  endtask

  task automatic send_item(input logic is_cmd, input logic flame,
                           input logic [CODE_W-1:0] cmd, input logic typed,
                           input res_t want);
    int gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 15);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= is_cmd;
    in_tdata  <= {7'd0, cmd, flame};
    do @(posedge clk); while (!in_fire);
    alarm_step(is_cmd, flame, cmd);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_fire);
    case (idx)
      CFG_POLL:   poll_ival = val[IVAL_W-1:0];
      CFG_TOGGLE: toggle_ival = val[IVAL_W-1:0];
      CFG_WD:     wd_limit = val;
      default: ;
    endcase
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_regs(input logic [WD_W-1:0] poll, input logic [WD_W-1:0] toggle,
                          input logic [WD_W-1:0] wd);
    settle();
    write_reg(CFG_POLL, poll);
    write_reg(CFG_TOGGLE, toggle);
    write_reg(CFG_WD, wd);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CODE_W-1:0] pick_cmd(input int k);
    case (k)
      0: return CMD_GREEN;
      1: return CMD_YELLOW;
      2: return CMD_RED;
      3: return CMD_FIRE;
      4: return CMD_STOP;
      5: return CMD_BUZZ;
      6: return CMD_QUIET;
      default: return CMD_HEART;
    endcase
  endfunction

  // Mostly ticks following a sticky flame level, with long command-free runs
  // now and then so that the watchdog gets a chance to expire.
  task automatic run_random(input int count);
    int                run_left;
    int                roll;
    logic              f;
    logic [CODE_W-1:0] c;
    run_left = 0;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) flame_level = ~flame_level;
      c = CODE_W'($urandom_range(0, 255));
      if (run_left == 0 && roll < 3) run_left = $urandom_range(10, 60);
      if (run_left > 0 || roll < 55) begin
        f = ($urandom_range(0, 19) == 0) ? ~flame_level : flame_level;
        if (run_left > 0) run_left--;
        send_item(1'b0, f, c, 1'b0, '0);
      end else if (roll < 90) begin
        send_item(1'b1, 1'($urandom), pick_cmd($urandom_range(0, 9)), 1'b0, '0);
      end else begin
        send_item(1'b1, 1'($urandom), c, 1'b0, '0);
      end
    end
  endtask

  function automatic row_t tick_row(input logic f, input logic [CODE_W-1:0] c);
    row_t t;
    t = '0;
    t.flame = f;
    t.cmd = c;
    return t;
  endfunction

  function automatic row_t cmd_row(input logic f, input logic [CODE_W-1:0] c);
    row_t t;
    t = tick_row(f, c);
    t.is_cmd = 1'b1;
    return t;
  endfunction

  function automatic row_t reg_row(input logic [IDX_W-1:0] idx, input logic [WD_W-1:0] v);
    row_t t;
    t = '0;
    t.is_reg = 1'b1;
    t.reg_idx = idx;
    t.reg_val = v;
    return t;
  endfunction

  function automatic row_t with_want(input row_t r, input res_t w);
    row_t t;
    t = r;
    t.typed = 1'b1;
    t.want = w;
    return t;
  endfunction

  initial begin
    res_t dark;
    dark = lamp_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, MSG_NONE, 1'b1);
    stim_table = '{
      with_want(tick_row(1'b0, 8'h00), dark),
      with_want(cmd_row(1'b0, CMD_GREEN),
                lamp_res(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, MSG_NONE, 1'b1)),
      with_want(cmd_row(1'b0, CMD_YELLOW),
                lamp_res(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, MSG_NONE, 1'b1)),
      with_want(cmd_row(1'b0, CMD_RED),
                lamp_res(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, MSG_NONE, 1'b1)),
      with_want(cmd_row(1'b0, CMD_FIRE),
                lamp_res(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, MSG_NONE, 1'b1)),
      tick_row(1'b1, 8'hFF),
      with_want(cmd_row(1'b0, CMD_QUIET),
                lamp_res(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, MSG_NONE, 1'b1)),
      cmd_row(1'b0, CMD_BUZZ),
      tick_row(1'b0, 8'h00),
      with_want(cmd_row(1'b0, CMD_STOP), dark),
      tick_row(1'b0, 8'h00),
      with_want(cmd_row(1'b0, CMD_HEART),
                lamp_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, MSG_HEART, 1'b1)),
      with_want(cmd_row(1'b1, 8'h00), dark),
      with_want(cmd_row(1'b0, 8'hFF), dark),
      cmd_row(1'b1, CMD_BUZZ),
      reg_row(CFG_POLL, 20'd1),
      reg_row(CFG_TOGGLE, 20'd2),
      reg_row(CFG_WD, 20'd6),
      tick_row(1'b1, 8'hAA),
      cmd_row(1'b0, CMD_HEART),
      tick_row(1'b0, 8'h55),
      cmd_row(1'b0, CMD_RED),
      tick_row(1'b0, 8'h00),
      tick_row(1'b0, 8'h00),
      tick_row(1'b0, 8'h00),
      tick_row(1'b0, 8'h00),
      tick_row(1'b0, 8'h00),
      tick_row(1'b0, 8'h00),
      tick_row(1'b0, 8'h00)
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(stim_table); i++) begin
      if (stim_table[i].is_reg) begin
        if (i == 0 || !stim_table[i-1].is_reg) settle();
        write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
        if (i + 1 == $size(stim_table) || !stim_table[i+1].is_reg) cfg_valid <= 1'b0;
      end else begin
        send_item(stim_table[i].is_cmd, stim_table[i].flame, stim_table[i].cmd,
                  stim_table[i].typed, stim_table[i].want);
      end
    end

    idle_pct = 20;
    set_regs(20'd1, 20'd1, WD_MAX);
    run_random(150);

    idle_pct = 8;
    set_regs(20'd0, 20'd0, 20'd0);
    run_random(120);

    // Upper bits of the interval registers are dropped on write.
    idle_pct = 30;
    set_regs(20'hFFFFF, 20'd65535, 20'd1);
    write_reg(CFG_SPARE, WD_W'($urandom));
    cfg_valid <= 1'b0;
    run_random(120);

    idle_pct = 15;
    set_regs(20'd3, 20'd4, 20'd40);
    run_random(180);

    idle_pct = $urandom_range(5, 35);
    set_regs(WD_W'($urandom_range(1, 6)), WD_W'($urandom_range(1, 10)),
             WD_W'($urandom_range(10, 120)));
    run_random(150);

    idle_pct = 0;
    set_regs(20'd2, 20'd3, 20'd25);
    run_random(150);

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
